@@ rtl/sfr_pkg.sv @@
// package for the stream find and replace block
// types, constants and register codes used by most rtl files and the sim files; no dependencies

package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 16;
  localparam int COUNT_WIDTH_DEF     = 16;

  localparam int MAX_ITEMS     = 16;
  localparam int ITEM_IDX_W    = 4;
  localparam int ITEM_CNT_W    = 5;
  localparam int REPORT_CNT_W  = 16;
  localparam int REP_BYTES_W   = 128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_HIGH   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]              out_byte;
    logic                    byte_valid;
    logic                    last_item;
    logic [REPORT_CNT_W-1:0] replace_count;
    logic                    status;
  } out_item_t;

  typedef struct packed {
    logic [3:0]             pattern_length;
    logic [63:0]            pattern_bytes;
    logic [4:0]             replacement_length;
    logic [REP_BYTES_W-1:0] replacement_bytes;
  } cfg_t;

  typedef struct packed {
    logic [MAX_ITEMS*8-1:0]  items;
    logic [ITEM_CNT_W-1:0]   item_cnt;
    logic                    empty;
    logic                    last;
    logic [REPORT_CNT_W-1:0] replace_count;
    logic                    status;
  } burst_t;

endpackage

@@ rtl/sfr_stream_if.sv @@
// valid/ready stream channel carrying one payload struct per transaction
// payload type is set at instantiation, usually from sfr_pkg

interface sfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/stream_find_replace.sv @@
// top level of the streaming fixed pattern find and replace block
// depends on sfr_pkg, sfr_stream_if, sfr_cfg_regs, sfr_step and sfr_burst
//
// in_i carries one source byte per transaction with an end_of_stream flag;
// out_o carries result bytes, and the final transaction of each stream has
// last_item set with the saturated replace_count and status (1 when the
// stream was shorter than the pattern, with no data bytes).
// the cfg port writes pattern and replacement registers; the user is to write
// them only while the block is idle, which the block itself does not enforce.
// a byte is registered at the input, then one step compares the window and
// loads a burst of 0 to 16 result transactions into the output register.
// throughput is one byte per cycle while each byte yields at most one result
// and out_o is not stalled; a burst occupies the output register until its last
// transaction is taken, and the input stage holds its byte until then.
// a stalled receiver holds out_o stable and backs up into in_i.ready.
// reset clears the window fill, count, valid flags and the registers to
// pattern length 1, empty replacement.

module stream_find_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
  parameter int COUNT_WIDTH     = sfr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  sfr_stream_if.sink                     in_i,
  sfr_stream_if.source                   out_o
);

  sfr_pkg::cfg_t      cfg;
  sfr_pkg::in_item_t  in_item_q;
  sfr_pkg::burst_t    burst;
  sfr_pkg::out_item_t out_item;
  logic               in_valid_q, step_fire, burst_free, out_valid;

  sfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign step_fire = in_valid_q && burst_free;
  assign in_i.ready = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.payload;
    end
  end

  sfr_step #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_fire),
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .burst_o (burst)
  );

  sfr_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_fire),
    .burst_i     (burst),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .free_o      (burst_free)
  );

  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule

@@ rtl/sfr_cfg_regs.sv @@
// configuration register file for the stream find and replace block
// depends on sfr_pkg for register codes and the cfg_t struct

module sfr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output sfr_pkg::cfg_t                 cfg_o
);

  sfr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pattern_length:     4'd1,
                 pattern_bytes:      '0,
                 replacement_length: '0,
                 replacement_bytes:  '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfr_pkg::CFG_PATTERN_LENGTH:     cfg_q.pattern_length <= cfg_wdata_i[3:0];
        sfr_pkg::CFG_PATTERN_BYTES:      cfg_q.pattern_bytes <= cfg_wdata_i;
        sfr_pkg::CFG_REPLACEMENT_LENGTH: cfg_q.replacement_length <= cfg_wdata_i[4:0];
        sfr_pkg::CFG_REPLACEMENT_LOW:    cfg_q.replacement_bytes[63:0] <= cfg_wdata_i;
        sfr_pkg::CFG_REPLACEMENT_HIGH:   cfg_q.replacement_bytes[127:64] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/sfr_step.sv @@
// match window, counters and the step that turns one byte into a burst
// depends on sfr_pkg for cfg_t, in_item_t and burst_t

module sfr_step #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF,
  parameter int COUNT_WIDTH     = sfr_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sfr_pkg::in_item_t item_i,
  input  sfr_pkg::cfg_t     cfg_i,
  output sfr_pkg::burst_t   burst_o
);

  localparam int FW = $clog2(MAX_PATTERN + 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [MAX_PATTERN-1:0][7:0] win_q, win_app, win_new;
  logic [FW-1:0]               fill_q, fill_d, fill_app, fill_new, tail_n;
  logic [COUNT_WIDTH-1:0]      match_q, match_d, match_new;
  logic                        reached_q, reached_d, reached_new;
  logic [3:0]                  plen, rm;
  logic [4:0]                  rlen, head_n;
  logic                        active, hit, last;
  logic [sfr_pkg::REP_BYTES_W-1:0] head_vec, tail_vec;
  logic [5:0]                  sum;
  logic [31:0]                 cnt_ext;
  sfr_pkg::burst_t             burst;

  always_comb begin
    if (cfg_i.pattern_length == 4'd0) begin
      plen = 4'd1;
    end else if (cfg_i.pattern_length > 4'(MAX_PATTERN)) begin
      plen = 4'(MAX_PATTERN);
    end else begin
      plen = cfg_i.pattern_length;
    end
    if (cfg_i.replacement_length > 5'(MAX_REPLACEMENT)) begin
      rlen = 5'(MAX_REPLACEMENT);
    end else begin
      rlen = cfg_i.replacement_length;
    end
  end

  // append, compare, remove
  always_comb begin
    last    = item_i.end_of_stream;
    win_app = win_q;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (FW'(k) == fill_q) begin
        win_app[k] = item_i.data_byte;
      end
    end
    fill_app = (fill_q < FW'(MAX_PATTERN)) ? fill_q + FW'(1) : fill_q;
    active   = 4'(fill_app) >= plen;
    hit      = active;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (4'(k) < plen && win_app[k] != cfg_i.pattern_bytes[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
    rm = hit ? plen : 4'd1;
    if (active) begin
      win_new  = win_app >> {rm, 3'b000};
      fill_new = fill_app - FW'(rm);
      head_n   = hit ? rlen : 5'd1;
    end else begin
      win_new  = win_app;
      fill_new = fill_app;
      head_n   = 5'd0;
    end
    reached_new = reached_q | active;
    match_new   = (hit && match_q != CountMax) ? match_q + COUNT_WIDTH'(1) : match_q;
  end

  // burst assembly: head bytes, then the flushed window on the final byte
  always_comb begin
    head_vec = hit ? cfg_i.replacement_bytes
                   : sfr_pkg::REP_BYTES_W'(win_app[0]);
    tail_n   = (last && reached_new) ? fill_new : '0;
    tail_vec = sfr_pkg::REP_BYTES_W'(win_new) << {head_n, 3'b000};
    for (int j = 0; j < sfr_pkg::MAX_ITEMS; j++) begin
      burst.items[8*j +: 8] = (5'(j) < head_n) ? head_vec[8*j +: 8] : tail_vec[8*j +: 8];
    end
    sum     = 6'(head_n) + 6'(tail_n);
    cnt_ext = 32'(match_new);
    burst.item_cnt      = (sum > 6'(sfr_pkg::MAX_ITEMS)) ? 5'(sfr_pkg::MAX_ITEMS) : sum[4:0];
    burst.empty         = 1'b0;
    burst.last          = last;
    burst.status        = 1'b0;
    burst.replace_count = cnt_ext[sfr_pkg::REPORT_CNT_W-1:0];
    if (last) begin
      if (!reached_new) begin
        burst.item_cnt      = 5'd1;
        burst.empty         = 1'b1;
        burst.status        = 1'b1;
        burst.replace_count = '0;
      end else if (sum == 6'd0) begin
        burst.item_cnt = 5'd1;
        burst.empty    = 1'b1;
      end
    end
  end

  assign burst_o = burst;

  always_comb begin
    if (last) begin
      fill_d    = '0;
      match_d   = '0;
      reached_d = 1'b0;
    end else begin
      fill_d    = fill_new;
      match_d   = match_new;
      reached_d = reached_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      match_q   <= '0;
      reached_q <= 1'b0;
    end else if (step_i) begin
      fill_q    <= fill_d;
      match_q   <= match_d;
      reached_q <= reached_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win_q <= win_new;
    end
  end

endmodule

@@ rtl/sfr_burst.sv @@
// result register for one burst, handed out one transaction per cycle while ready
// depends on sfr_pkg for burst_t and out_item_t

module sfr_burst (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sfr_pkg::burst_t     burst_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output sfr_pkg::out_item_t  out_item_o,
  output logic                free_o
);

  logic                              valid_q;
  logic [sfr_pkg::ITEM_IDX_W-1:0]    idx_q;
  sfr_pkg::burst_t                   burst_q;
  logic                              out_fire, final_item;

  assign out_fire   = valid_q && out_ready_i;
  assign final_item = (5'(idx_q) + 5'd1) == burst_q.item_cnt;
  assign free_o     = !valid_q || (out_fire && final_item);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i && burst_i.item_cnt != '0) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (out_fire) begin
      if (final_item) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  always_comb begin
    out_item_o.byte_valid    = !burst_q.empty;
    out_item_o.out_byte      = burst_q.empty ? 8'd0 : burst_q.items[{idx_q, 3'b000} +: 8];
    out_item_o.last_item     = burst_q.last && final_item;
    out_item_o.replace_count = out_item_o.last_item ? burst_q.replace_count : '0;
    out_item_o.status        = out_item_o.last_item && burst_q.status;
  end

  assign out_valid_o = valid_q;

endmodule

@@ rtl/sfr_checker.sv @@
// port level checks for stream_find_replace and the bind that attaches them
// depends on the top level's port names only

module sfr_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        byte_valid_i,
  input logic        last_item_i,
  input logic [15:0] replace_count_i,
  input logic        status_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(byte_valid_i) && $stable(last_item_i)
      && $stable(replace_count_i) && $stable(status_i))
    else $error("result transaction changed while stalled");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> last_item_i && !byte_valid_i && replace_count_i == 16'd0)
    else $error("short stream status outside an empty closing transaction");

  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && replace_count_i != 16'd0 |-> last_item_i)
    else $error("replace count shown before the end of the stream");

  a_empty_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> last_item_i && out_byte_i == 8'd0)
    else $error("empty transaction that does not close the stream");

endmodule

bind stream_find_replace sfr_port_checks u_port_checks (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_byte_i      (out_o.payload.out_byte),
  .byte_valid_i    (out_o.payload.byte_valid),
  .last_item_i     (out_o.payload.last_item),
  .replace_count_i (out_o.payload.replace_count),
  .status_i        (out_o.payload.status)
);

@@ sim/sfr_checker.sv @@
// transaction checker for stream_find_replace: tracks register writes, predicts
// the result transactions of every accepted byte and compares them in order
// depends on sfr_pkg only; counts mismatches and reports pending expectations

module sfr_checker
  import sfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_payload_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_payload_i,
  output int                    err_count_o,
  output int                    pending_o
);

  localparam int unsigned WIN_DEPTH = MAX_PATTERN_DEF;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_MAX = '1;

  logic [3:0]  pat_len_q;
  logic [63:0] pat_bytes_q;
  logic [4:0]  rep_len_q;
  logic [63:0] rep_low_q;
  logic [63:0] rep_high_q;

  logic [7:0]                 window_q [WIN_DEPTH];
  int unsigned                fill_q;
  logic [COUNT_WIDTH_DEF-1:0] replaced_q;
  logic                       reached_q;

  out_item_t result_q [$];
  out_item_t want;
  int        mismatches = 0;

  assign err_count_o = mismatches;

  function automatic void compare_field(string name, longint unsigned exp_val,
                                        longint unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  function automatic void find_replace_step(in_item_t item);
    int unsigned  plen;
    int unsigned  rlen;
    int unsigned  i;
    logic         hit;
    logic [127:0] rep_bytes;
    logic [7:0]   emitted [$];
    out_item_t    step_q [$];
    out_item_t    res;
    plen = (pat_len_q == 0) ? 1 : (pat_len_q > WIN_DEPTH) ? WIN_DEPTH : pat_len_q;
    rlen = (rep_len_q > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : rep_len_q;
    rep_bytes = {rep_high_q, rep_low_q};

    if (fill_q < WIN_DEPTH) begin
      window_q[fill_q] = item.data_byte;
      fill_q++;
    end

    if (fill_q >= plen) begin
      reached_q = 1'b1;
      hit = 1'b1;
      for (i = 0; i < plen; i++)
        if (window_q[i] != pat_bytes_q[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < rlen; i++) emitted.push_back(rep_bytes[8*i +: 8]);
        for (i = 0; i + plen < fill_q; i++) window_q[i] = window_q[i + plen];
        fill_q -= plen;
        if (replaced_q != COUNT_MAX) replaced_q++;
      end else begin
        emitted.push_back(window_q[0]);
        for (i = 1; i < fill_q; i++) window_q[i - 1] = window_q[i];
        fill_q--;
      end
    end

    // a stream that never filled the pattern gives no data at all
    if (item.end_of_stream) begin
      if (!reached_q) emitted.delete();
      else for (i = 0; i < fill_q; i++) emitted.push_back(window_q[i]);
    end

    for (i = 0; i < emitted.size() && i < MAX_ITEMS; i++) begin
      res = '0;
      res.out_byte = emitted[i];
      res.byte_valid = 1'b1;
      step_q.push_back(res);
    end

    if (item.end_of_stream) begin
      if (step_q.size() == 0) step_q.push_back('0);
      res = step_q.pop_back();
      res.last_item = 1'b1;
      res.status = !reached_q;
      res.replace_count = reached_q ? REPORT_CNT_W'(replaced_q) : '0;
      step_q.push_back(res);
      fill_q = 0;
      replaced_q = '0;
      reached_q = 1'b0;
    end

    foreach (step_q[j]) result_q.push_back(step_q[j]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q = 4'd1;
      pat_bytes_q = '0;
      rep_len_q = '0;
      rep_low_q = '0;
      rep_high_q = '0;
      fill_q = 0;
      replaced_q = '0;
      reached_q = 1'b0;
      mismatches = 0;
      result_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN_LENGTH:     pat_len_q = cfg_wdata_i[3:0];
          CFG_PATTERN_BYTES:      pat_bytes_q = cfg_wdata_i;
          CFG_REPLACEMENT_LENGTH: rep_len_q = cfg_wdata_i[4:0];
          CFG_REPLACEMENT_LOW:    rep_low_q = cfg_wdata_i;
          CFG_REPLACEMENT_HIGH:   rep_high_q = cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result transaction with none expected: out_byte %0h last_item %0b",
                 out_payload_i.out_byte, out_payload_i.last_item);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          compare_field("out_byte", want.out_byte, out_payload_i.out_byte);
          compare_field("byte_valid", want.byte_valid, out_payload_i.byte_valid);
          compare_field("last_item", want.last_item, out_payload_i.last_item);
          compare_field("replace_count", want.replace_count, out_payload_i.replace_count);
          compare_field("status", want.status, out_payload_i.status);
        end
      end

      if (in_valid_i && in_ready_i) find_replace_step(in_payload_i);

      pending_o <= result_q.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
// top of the stream_find_replace simulation: clock, reset, register writes,
// byte streams and random backpressure; sfr_checker does the comparison
// depends on sfr_pkg, sfr_stream_if, stream_find_replace and sfr_checker

module testbench;
  import sfr_pkg::*;

  localparam int RANDOM_ITEMS   = 200;
  localparam int DRAIN_SLACK    = 8;
  localparam int CYCLE_LIMIT    = 1_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    source_gaps;
  bit                    sink_stalls;
  int                    err_count;
  int                    pending;
  int                    cycles = 0;

  sfr_stream_if #(.payload_t(in_item_t))  in_ch ();
  sfr_stream_if #(.payload_t(out_item_t)) out_ch ();

  stream_find_replace u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  sfr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_payload_i (in_ch.payload),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_payload_i(out_ch.payload),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  initial begin : sink_side
    int unsigned stall_left;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n;
        if (sink_stalls && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic closes);
    in_item_t item;
    if (source_gaps && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
    item.data_byte = value;
    item.end_of_stream = closes;
    in_ch.valid <= 1'b1;
    in_ch.payload <= item;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic send_stream(input logic [7:0] data [$], input logic closes);
    foreach (data[i]) begin
      send_byte(data[i], closes && (i == data.size() - 1));
      // now and then hold off until every expected transaction is out
      if (i < data.size() - 1 && $urandom_range(0, 39) == 0) drain();
    end
  endtask

  task automatic set_config(input logic [3:0] plen, input logic [63:0] pat,
                            input logic [4:0] rlen, input logic [63:0] rlo,
                            input logic [63:0] rhi);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_PATTERN_LENGTH;
    cfg_wdata <= CFG_DATA_W'(plen);
    @(posedge clk);
    cfg_idx <= CFG_PATTERN_BYTES;
    cfg_wdata <= pat;
    @(posedge clk);
    cfg_idx <= CFG_REPLACEMENT_LENGTH;
    cfg_wdata <= CFG_DATA_W'(rlen);
    @(posedge clk);
    cfg_idx <= CFG_REPLACEMENT_LOW;
    cfg_wdata <= rlo;
    @(posedge clk);
    cfg_idx <= CFG_REPLACEMENT_HIGH;
    cfg_wdata <= rhi;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [3:0]  plen;
    logic [4:0]  rlen;
    logic [63:0] pat;
    logic [7:0]  bytes [$];
    int unsigned eff_plen;
    int unsigned len;
    int unsigned sent;
    int unsigned sel;
    int unsigned k;
    int unsigned j;

    rst_n = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_PATTERN_LENGTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: single zero byte pattern, empty replacement
    bytes = {8'h00, 8'hFF};
    send_stream(bytes, 1'b1);

    // full sixteen byte replacement, then a stream shorter than the pattern
    drain();
    set_config(4'd2, 64'h00FF, 5'd16, {$urandom, $urandom}, {$urandom, $urandom});
    bytes = {8'hFF, 8'h00, 8'hFF};
    send_stream(bytes, 1'b1);
    bytes = {8'h7E};
    send_stream(bytes, 1'b1);

    // longest pattern deleted on the final byte: empty closing transaction
    drain();
    pat = {$urandom, $urandom};
    set_config(4'd8, pat, 5'd0, '0, '0);
    bytes.delete();
    for (k = 0; k < 8; k++) bytes.push_back(pat[8*k +: 8]);
    send_stream(bytes, 1'b1);

    // out of range lengths: zero pattern length and oversized replacement
    drain();
    set_config(4'd0, 64'h55, 5'd31, {$urandom, $urandom}, {$urandom, $urandom});
    bytes = {8'h55};
    send_stream(bytes, 1'b1);

    // registers changed mid-stream so that one byte yields more than sixteen
    drain();
    set_config(4'd15, {$urandom, $urandom}, 5'd1, {$urandom, $urandom}, '0);
    bytes.delete();
    for (k = 0; k < 7; k++) bytes.push_back(8'($urandom));
    send_stream(bytes, 1'b0);
    drain();
    set_config(4'd1, CFG_DATA_W'(bytes[0]), 5'd16, {$urandom, $urandom},
               {$urandom, $urandom});
    send_byte(8'($urandom), 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      source_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      sel = $urandom_range(0, 9);
      if (sel == 0) plen = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
      else if (sel < 7) plen = 4'($urandom_range(1, 3));
      else plen = 4'($urandom_range(4, 8));
      eff_plen = (plen == 0) ? 1 : (plen > 8) ? 8 : plen;
      rlen = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                         : 5'($urandom_range(0, 16));
      pat = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0)
        for (k = 0; k < 8; k++) pat[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
      set_config(plen, pat, rlen, {$urandom, $urandom}, {$urandom, $urandom});

      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff_plen)
                                          : $urandom_range(1, 24);
        bytes.delete();
        while (bytes.size() < len) begin
          case ($urandom_range(0, 4))
            0, 1: for (j = 0; j < eff_plen; j++) bytes.push_back(pat[8*j +: 8]);
            2: begin
              k = $urandom_range(1, eff_plen);
              for (j = 0; j < k; j++) bytes.push_back(pat[8*j +: 8]);
            end
            3: bytes.push_back(pat[8*$urandom_range(0, eff_plen - 1) +: 8]);
            default: bytes.push_back(8'($urandom));
          endcase
        end
        while (bytes.size() > len) void'(bytes.pop_back());
        send_stream(bytes, 1'b1);
        sent += bytes.size();
      end
    end

    drain();
    if (err_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
